>>> rtl/fpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpq_pkg: shared types and constants of the priority queue
// Depth, operation and status codes, and the entry, cell control and result types.
// ----------------------------------------------------------------------------
package fpq_pkg;

  // Number of cells in the row
  localparam int unsigned DEPTH = 16;
  // Count register width, wide enough to hold DEPTH itself
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned PRI_W    = 8;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCNT_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Per-cell update select
  typedef struct packed {
    logic load_new;
    logic take_left;
    logic take_right;
  } cell_ctrl_t;

  typedef struct packed {
    logic                valid;
    logic [TAG_W-1:0]    tag;
    logic [PRI_W-1:0]    pri;
    logic [STATUS_W-1:0] status;
    logic [OCNT_W-1:0]   count;
    logic                empty;
  } result_t;

endpackage

>>> rtl/fpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpq_cell: one slot of the sorted row
// Holds one entry; loads the new entry, the left neighbor's or the right
// neighbor's as the control says, and flags when its priority is below the
// incoming one.
// ----------------------------------------------------------------------------
module fpq_cell (
  input  logic                clk_i,
  input  fpq_pkg::cell_ctrl_t ctrl_i,
  input  fpq_pkg::entry_t     new_i,
  input  fpq_pkg::entry_t     left_i,
  input  fpq_pkg::entry_t     right_i,
  output fpq_pkg::entry_t     data_o,
  output logic                lower_o
);

  fpq_pkg::entry_t data_q;
  fpq_pkg::entry_t data_d;

  // Pick the next content of the slot
  always_comb begin
    data_d = data_q;
    if (ctrl_i.load_new) begin
      data_d = new_i;
    end else if (ctrl_i.take_left) begin
      data_d = left_i;
    end else if (ctrl_i.take_right) begin
      data_d = right_i;
    end
  end

  // Hold the entry
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign lower_o = data_q.pri < new_i.pri;

endmodule

>>> rtl/fifo_priority_queue_top.sv
`timescale 1ns / 1ps
// Result: the result word of an operation is registered and appears in the cycle after it is taken.
// Throughput: one operation per cycle while the result side is not stalled; the whole
// cell row shifts at once and a single output register decouples the result side.
// Reset: clears the entry count and the output valid; cell contents are left
// as they are, since only cells below the count are ever read.
// ----------------------------------------------------------------------------
// fifo_priority_queue_top: bounded priority queue on a shifting cell row
// Append, insert by priority (stable among equal priorities) and remove front,
// each answered by one result word with status, count and empty flag.
// ----------------------------------------------------------------------------
module fifo_priority_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] opcode, [9:2] item_priority, [25:10] item_tag
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] out_valid, [16:1] out_tag, [24:17] out_priority, [26:25] status,
  // [31:27] entry_count, [32] is_empty
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned DEPTH = fpq_pkg::DEPTH;
  localparam int unsigned CNT_W = fpq_pkg::CNT_W;

  logic [CNT_W-1:0]    count_q, count_d;
  logic                m_valid_q;
  fpq_pkg::result_t    res_q, res_d;

  fpq_pkg::op_e        op;
  fpq_pkg::entry_t     new_entry;
  logic                accept;
  logic                full;
  logic                empty;
  logic                ins_ok;
  logic                rem_ok;
  logic                is_insert;

  fpq_pkg::entry_t     cell_data [DEPTH];
  fpq_pkg::cell_ctrl_t cell_ctrl [DEPTH];
  logic [DEPTH-1:0]    cell_lower;
  logic [DEPTH-1:0]    occ;
  logic [DEPTH-1:0]    lower;
  logic [DEPTH-1:0]    from_first;
  logic [DEPTH-1:0]    at_pos;
  logic [DEPTH-1:0]    at_prev;

  // Unpack the input word
  assign op            = fpq_pkg::op_e'(s_axis_tdata[1:0]);
  assign new_entry.pri = s_axis_tdata[9:2];
  assign new_entry.tag = s_axis_tdata[25:10];

  assign s_axis_tready = ~m_valid_q | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  assign full      = count_q == CNT_W'(DEPTH);
  assign empty     = count_q == '0;
  assign is_insert = op == fpq_pkg::OP_INSERT;
  assign ins_ok    = accept & ~full & (op == fpq_pkg::OP_APPEND || is_insert);
  assign rem_ok    = accept & ~empty & (op == fpq_pkg::OP_REMOVE);

  // Occupancy thermometer and lower-priority flags of held cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_occ
    assign occ[i] = CNT_W'(i) < count_q;
  end
  assign lower = occ & cell_lower;

  // Mark every cell from the first lower-priority one upward
  assign from_first = lower | (~lower + DEPTH'(1));
  assign at_pos     = ~occ | ({DEPTH{is_insert}} & from_first);
  assign at_prev    = {at_pos[DEPTH-2:0], 1'b0};

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fpq_pkg::entry_t left_s;
    fpq_pkg::entry_t right_s;

    if (i == 0) begin : g_first
      assign left_s = new_entry;
    end else begin : g_left
      assign left_s = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_s = cell_data[i];
    end else begin : g_right
      assign right_s = cell_data[i+1];
    end

    assign cell_ctrl[i].load_new   = ins_ok & at_pos[i] & ~at_prev[i];
    assign cell_ctrl[i].take_left  = ins_ok & at_pos[i] & at_prev[i];
    assign cell_ctrl[i].take_right = rem_ok;

    fpq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[i]),
      .new_i   (new_entry),
      .left_i  (left_s),
      .right_i (right_s),
      .data_o  (cell_data[i]),
      .lower_o (cell_lower[i])
    );
  end

  // Next count and result word
  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (rem_ok) begin
      count_d = count_q - CNT_W'(1);
    end

    res_d        = '0;
    res_d.status = fpq_pkg::ST_DONE;
    unique case (op) inside
      fpq_pkg::OP_APPEND, fpq_pkg::OP_INSERT: begin
        if (full) begin
          res_d.status = fpq_pkg::ST_FULL;
        end
      end
      fpq_pkg::OP_REMOVE: begin
        if (empty) begin
          res_d.status = fpq_pkg::ST_EMPTY;
        end else begin
          res_d.valid = 1'b1;
          res_d.tag   = cell_data[0].tag;
          res_d.pri   = cell_data[0].pri;
        end
      end
      default: begin
        res_d.status = fpq_pkg::ST_DONE;
      end
    endcase
    res_d.count = fpq_pkg::OCNT_W'(count_d);
    res_d.empty = count_d == '0;
  end

  // Hold count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, res_q.empty, res_q.count, res_q.status,
                          res_q.pri, res_q.tag, res_q.valid};

endmodule

>>> rtl/fpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpq_checker: port-level checks of the priority queue
// Watches the result channel for consistent status, count and empty flags.
// ----------------------------------------------------------------------------
module fpq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // Stalled result word holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // A returned entry comes only with a done status
  a_valid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[26:25] == 2'd0)
    else $error("returned entry with non-done status");

  // Empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[32] == (m_axis_tdata[31:27] == 5'd0))
    else $error("empty flag disagrees with count");

  // Remove from empty returns nothing and leaves the queue empty
  a_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[26:25] == 2'd2
      |-> !m_axis_tdata[0] && m_axis_tdata[32] && m_axis_tdata[24:1] == 24'd0)
    else $error("bad result for remove from empty");

endmodule

bind fifo_priority_queue_top fpq_checker u_fpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/fpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpq_scoreboard: result checker for the priority queue
// Watches both stream channels and keeps its own copy of the cell row.
// Each taken operation word gives one predicted result word. Each result
// word that leaves the block is compared, field by field, against the oldest
// prediction. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module fpq_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Shadow copy of the queue, front first
  fpq_pkg::entry_t  shadow_row [fpq_pkg::DEPTH];
  int unsigned      shadow_count;
  // Predicted result words, oldest first
  fpq_pkg::result_t predicted_results [$];
  int unsigned      result_idx;

  // Apply one operation to the shadow queue and return its result word
  function automatic fpq_pkg::result_t apply_queue_op(
    fpq_pkg::op_e                op,
    logic [fpq_pkg::PRI_W-1:0]   pri,
    logic [fpq_pkg::TAG_W-1:0]   tag
  );
    fpq_pkg::result_t res;
    int unsigned      pos;
    int unsigned      i;
    logic             found;
    res        = '0;
    res.status = fpq_pkg::ST_DONE;
    case (op) inside
      fpq_pkg::OP_APPEND, fpq_pkg::OP_INSERT: begin
        if (shadow_count >= fpq_pkg::DEPTH) begin
          res.status = fpq_pkg::ST_FULL;
        end else begin
          pos = shadow_count;
          if (op == fpq_pkg::OP_INSERT) begin
            // Stop at the first held entry of strictly lower priority
            found = 1'b0;
            for (i = 0; i < shadow_count && !found; i++) begin
              if (shadow_row[i].pri < pri) begin
                pos   = i;
                found = 1'b1;
              end
            end
          end
          // Open a gap at pos by shifting toward the rear
          for (i = shadow_count; i > pos; i--) begin
            shadow_row[i] = shadow_row[i-1];
          end
          shadow_row[pos].pri = pri;
          shadow_row[pos].tag = tag;
          shadow_count++;
        end
      end
      fpq_pkg::OP_REMOVE: begin
        if (shadow_count == 0) begin
          res.status = fpq_pkg::ST_EMPTY;
        end else begin
          res.valid = 1'b1;
          res.tag   = shadow_row[0].tag;
          res.pri   = shadow_row[0].pri;
          for (i = 1; i < shadow_count; i++) begin
            shadow_row[i-1] = shadow_row[i];
          end
          shadow_count--;
        end
      end
      default: begin
        // Unused opcode: leave the queue as it is
      end
    endcase
    res.count = fpq_pkg::OCNT_W'(shadow_count);
    res.empty = (shadow_count == 0);
    return res;
  endfunction

  // Compare leaving result words, then predict for the taken operation word
  always @(posedge clk_i or negedge rst_ni) begin
    fpq_pkg::result_t got;
    fpq_pkg::result_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      predicted_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      result_idx   = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.valid  = m_tdata_i[0];
        got.tag    = m_tdata_i[16:1];
        got.pri    = m_tdata_i[24:17];
        got.status = m_tdata_i[26:25];
        got.count  = m_tdata_i[31:27];
        got.empty  = m_tdata_i[32];
        if (predicted_results.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: result word %0d arrived with none expected: %h",
                     $realtime, result_idx, m_tdata_i);
          end
          fail_count_o++;
        end else begin
          want = predicted_results.pop_front();
          if (got.valid !== want.valid || got.tag !== want.tag ||
              got.pri !== want.pri || got.status !== want.status ||
              got.count !== want.count || got.empty !== want.empty) begin
            if (fail_count_o < 10) begin
              $display("%0t: result word %0d mismatch", $realtime, result_idx);
              $display("  valid exp %0d got %0d, tag exp %h got %h, pri exp %0d got %0d",
                       want.valid, got.valid, want.tag, got.tag, want.pri, got.pri);
              $display("  status exp %0d got %0d, count exp %0d got %0d, empty exp %0d got %0d",
                       want.status, got.status, want.count, got.count,
                       want.empty, got.empty);
            end
            fail_count_o++;
          end
        end
        result_idx++;
      end
      if (s_tvalid_i && s_tready_i) begin
        predicted_results.push_back(apply_queue_op(fpq_pkg::op_e'(s_tdata_i[1:0]),
                                                   s_tdata_i[9:2],
                                                   s_tdata_i[25:10]));
      end
      pending_o = predicted_results.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the priority queue
// Runs a short directed sequence over the corner cases, then three random
// phases that swing the queue between full and empty under changing
// sender and receiver idling. Checking lives in fpq_scoreboard.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PHASE_OPS    = 563;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles  = 0;

  always #5 clk_i = ~clk_i;

  fifo_priority_queue_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fpq_scoreboard u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  // Stall the result side at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one operation word, called at a falling edge; returns at one
  task automatic send_op(fpq_pkg::op_e op, logic [fpq_pkg::PRI_W-1:0] pri,
                         logic [fpq_pkg::TAG_W-1:0] tag);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, tag, pri, op};
    do begin
      @(posedge clk_i);
    end while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  // Hold the sender until every predicted result word has been seen
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_results != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    int unsigned  phase;
    int unsigned  n;
    int unsigned  mode;
    int unsigned  roll;
    fpq_pkg::op_e op;
    fpq_pkg::op_e ins_op;
    logic [7:0]   pri;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty remove, unused opcode, priority ordering and ties
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_op(fpq_pkg::OP_REMOVE, 8'hff, 16'hffff);
    send_op(fpq_pkg::OP_NONE,   8'hff, 16'hffff);
    send_op(fpq_pkg::OP_APPEND, 8'hff, 16'hffff);
    send_op(fpq_pkg::OP_APPEND, 8'h00, 16'h0000);
    send_op(fpq_pkg::OP_INSERT, 8'h80, 16'h1234);
    send_op(fpq_pkg::OP_INSERT, 8'hff, 16'h5555);
    send_op(fpq_pkg::OP_INSERT, 8'h00, 16'haaaa);
    send_op(fpq_pkg::OP_INSERT, 8'h80, 16'h8001);
    send_op(fpq_pkg::OP_NONE,   8'h00, 16'h0000);
    repeat (7) send_op(fpq_pkg::OP_REMOVE, 8'h00, 16'h0000);
    send_op(fpq_pkg::OP_REMOVE, 8'h00, 16'h0000);
    wait_drained();

    // Random phases: swing between filling and draining
    mode = 2;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (n = 0; n < PHASE_OPS; n++) begin
        if (n % 50 == 0) begin
          mode = $urandom_range(0, 2);
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          op = fpq_pkg::OP_NONE;
        end else begin
          roll   = $urandom_range(0, 99);
          ins_op = $urandom_range(0, 1) ? fpq_pkg::OP_INSERT : fpq_pkg::OP_APPEND;
          case (mode)
            0:       op = (roll < 80) ? ins_op : fpq_pkg::OP_REMOVE;
            1:       op = (roll < 75) ? fpq_pkg::OP_REMOVE : ins_op;
            default: op = (roll < 50) ? ins_op : fpq_pkg::OP_REMOVE;
          endcase
        end
        // Favor a few priorities so ties are common
        case ($urandom_range(0, 3))
          0:       pri = 8'($urandom_range(0, 3));
          1:       pri = $urandom_range(0, 1) ? 8'hff : 8'h00;
          default: pri = 8'($urandom_range(0, 255));
        endcase
        send_op(op, pri, 16'($urandom_range(0, 65535)));
      end
      wait_drained();
    end

    if (fail_count == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
